@@ design/bsa_pkg.sv @@
// Package for the bitmap slot allocator: command and status codes, the
// transaction token that walks the cell chain, and the claim broadcast.
// No dependencies.
package bsa_pkg;

  localparam int DefaultNumBlocks = 16;
  localparam int MaxSlots         = 16;
  localparam int MapWidth         = 16;
  localparam int BlockIdxWidth    = 4;
  localparam int OffsetWidth      = 4;
  localparam int HandleWidth      = BlockIdxWidth + OffsetWidth;

  localparam logic [MapWidth-1:0] MapFull = {MapWidth{1'b1}};

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NOT_LIVE = 2'd2;

  // One transaction in flight through the chain of block cells.
  typedef struct packed {
    logic                     valid;
    logic                     cmd;
    logic [MapWidth-1:0]      mask;
    logic [BlockIdxWidth-1:0] blk;
    logic [OffsetWidth-1:0]   off;
    logic                     found;
    logic [HandleWidth-1:0]   handle;
    logic [1:0]               status;
    logic                     released;
    logic                     free_found;
    logic [BlockIdxWidth-1:0] free_idx;
  } token_t;

  // Broadcast that makes the first free block take a new map.
  typedef struct packed {
    logic                     valid;
    logic [BlockIdxWidth-1:0] idx;
    logic [MapWidth-1:0]      mask;
  } claim_t;

endpackage

@@ design/bsa_cell.sv @@
// One block cell: holds the unit map of a single block slot and updates the
// token passing through it. Depends on bsa_pkg.
module bsa_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  bsa_pkg::token_t tok_in,
  input  bsa_pkg::claim_t claim,
  output bsa_pkg::token_t tok_out
);

  localparam logic [bsa_pkg::BlockIdxWidth-1:0] Idx = bsa_pkg::BlockIdxWidth'(CELL_INDEX);

  logic [bsa_pkg::MapWidth-1:0]      map;
  logic [bsa_pkg::MapWidth-1:0]      map_next;
  bsa_pkg::token_t                   tok_next;
  logic [bsa_pkg::MapWidth-1:0]      fit_ok;
  logic [bsa_pkg::OffsetWidth-1:0]   fit_off;
  logic [2*bsa_pkg::MapWidth-1:0]    wide;
  logic [bsa_pkg::MapWidth-1:0]      placed;
  logic [bsa_pkg::MapWidth-1:0]      cleared;
  logic                              live;
  logic                              scan_hit;
  logic                              free_hit;

  // All sixteen offsets are checked side by side; the lowest one wins.
  always_comb begin
    for (int k = 0; k < bsa_pkg::MapWidth; k++) begin
      wide = {{bsa_pkg::MapWidth{1'b0}}, tok_in.mask} << k;
      fit_ok[k] = (wide[2*bsa_pkg::MapWidth-1:bsa_pkg::MapWidth] == '0) &&
                  ((wide[bsa_pkg::MapWidth-1:0] & map) == '0);
    end
    fit_off = '0;
    for (int k = bsa_pkg::MapWidth - 1; k >= 0; k--) begin
      if (fit_ok[k]) begin
        fit_off = bsa_pkg::OffsetWidth'(k);
      end
    end
  end

  assign placed  = bsa_pkg::MapWidth'(tok_in.mask << fit_off);
  assign cleared = map & ~bsa_pkg::MapWidth'(tok_in.mask << tok_in.off);
  assign live    = (map != '0) && (map != bsa_pkg::MapFull);

  assign scan_hit = tok_in.valid && (tok_in.cmd == bsa_pkg::CMD_ALLOC) && !tok_in.found &&
                    (tok_in.mask != bsa_pkg::MapFull) && live && (|fit_ok);
  assign free_hit = tok_in.valid && (tok_in.cmd == bsa_pkg::CMD_FREE) &&
                    (tok_in.blk == Idx) && (map != '0);

  always_comb begin
    tok_next = tok_in;
    map_next = map;
    priority if (claim.valid && (claim.idx == Idx)) begin
      map_next = claim.mask;
    end else if (scan_hit) begin
      map_next        = map | placed;
      tok_next.found  = 1'b1;
      tok_next.status = bsa_pkg::ST_OK;
      tok_next.handle = {Idx, fit_off};
    end else if (free_hit) begin
      map_next          = cleared;
      tok_next.status   = bsa_pkg::ST_OK;
      tok_next.released = (cleared == '0);
    end else begin
      map_next = map;
    end
    // Remember the lowest free slot in case no live block fits.
    if (tok_in.valid && (tok_in.cmd == bsa_pkg::CMD_ALLOC) && !tok_in.free_found &&
        (map == '0)) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = Idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map           <= '0;
      tok_out.valid <= 1'b0;
    end else begin
      map     <= map_next;
      tok_out <= tok_next;
    end
  end

endmodule

@@ design/bitmap_slot_allocator_core.sv @@
// Top level of the first-fit bitmap slot allocator: input stage, a chain of
// block cells, the final claim step, the holding register and the output register.
// Depends on bsa_pkg and bsa_cell.
//
// Usage. Requests arrive on the s_axis channel: tuser carries the command
// (allocate or free), tdata the unshifted run mask and, for a free, the handle
// (block index times 16 plus unit offset). Each request gives exactly one
// result on m_axis: tuser carries the status, tdata the allocated handle and
// the block-released flag.
// A request enters cell 0 and moves one cell per cycle; each cell owns the
// 16-bit unit map of one block slot and checks all sixteen offsets at once.
// After the last cell, an allocation that fit in no live block claims the
// lowest free slot seen on the way. From the last cell a result goes into
// the holding register and, once the output is free, into the output
// register that drives m_axis. One request is worked on at a time;
// s_axis_tready is low from its accept until its result moves into the
// output register.
// A finished result waits in the output register while the receiver stalls,
// and the next request is accepted meanwhile; its result waits in a holding
// register until the output frees up. Reset clears every unit map (all slots
// free) and empties the chain and both registers.
module bitmap_slot_allocator_core #(
  parameter int NUM_BLOCKS = bsa_pkg::DefaultNumBlocks
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] run_mask, [23:16] handle
  input  logic [0:0]  s_axis_tuser,  // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] alloc_handle, [8] block_released, rest zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  // The handle carries a four-bit block index, so at most sixteen slots.
  localparam int SlotCount = (NUM_BLOCKS < bsa_pkg::MaxSlots) ? NUM_BLOCKS : bsa_pkg::MaxSlots;

  bsa_pkg::token_t chain [SlotCount+1];
  bsa_pkg::token_t head;
  bsa_pkg::token_t last;
  bsa_pkg::claim_t claim;

  logic                            busy;
  logic                            accept;
  logic                            pend_valid;
  logic [1:0]                      pend_status;
  logic [bsa_pkg::HandleWidth-1:0] pend_handle;
  logic                            pend_released;
  logic [1:0]                      fin_status;
  logic [bsa_pkg::HandleWidth-1:0] fin_handle;
  logic                            move_out;
  logic [1:0]                      out_status;
  logic [bsa_pkg::HandleWidth-1:0] out_handle;
  logic                            out_released;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The accepted transaction becomes the token that enters the first cell.
  always_comb begin
    head            = '0;
    head.valid      = accept;
    head.cmd        = s_axis_tuser[0];
    head.mask       = s_axis_tdata[15:0];
    head.blk        = s_axis_tdata[23:20];
    head.off        = s_axis_tdata[19:16];
    head.status     = (s_axis_tuser[0] == bsa_pkg::CMD_FREE) ? bsa_pkg::ST_NOT_LIVE
                                                            : bsa_pkg::ST_NO_SPACE;
  end

  assign chain[0] = head;

  for (genvar g = 0; g < SlotCount; g++) begin : g_cell
    bsa_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[g]),
      .claim   (claim),
      .tok_out (chain[g+1])
    );
  end

  assign last = chain[SlotCount];

  // An allocation that fit nowhere falls back to the lowest free slot.
  always_comb begin
    claim       = '0;
    fin_status  = last.status;
    fin_handle  = last.handle;
    if (last.valid && (last.cmd == bsa_pkg::CMD_ALLOC) && !last.found && last.free_found) begin
      claim.valid = 1'b1;
      claim.idx   = last.free_idx;
      claim.mask  = last.mask;
      fin_status  = bsa_pkg::ST_OK;
      fin_handle  = {last.free_idx, {bsa_pkg::OffsetWidth{1'b0}}};
    end
  end

  assign move_out = pend_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (move_out) begin
        busy <= 1'b0;
      end
      if (last.valid) begin
        pend_valid <= 1'b1;
      end else if (move_out) begin
        pend_valid <= 1'b0;
      end
      if (move_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last.valid) begin
      pend_status   <= fin_status;
      pend_handle   <= fin_handle;
      pend_released <= last.released;
    end
    if (move_out) begin
      out_status   <= pend_status;
      out_handle   <= pend_handle;
      out_released <= pend_released;
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {7'b0, out_released, out_handle};

endmodule

@@ design/bsa_checker.sv @@
// Port-level checker for the bitmap slot allocator core, with its bind.
// Depends on bsa_pkg and bitmap_slot_allocator_core.
module bsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request accepted while one is in the chain");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == bsa_pkg::ST_OK) ||
                      (m_axis_tuser == bsa_pkg::ST_NO_SPACE) ||
                      (m_axis_tuser == bsa_pkg::ST_NOT_LIVE))
    else $error("unknown status code");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != bsa_pkg::ST_OK) |-> m_axis_tdata == 16'h0000)
    else $error("failed request carries a handle or a release");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:9] == 7'h00)
    else $error("padding bits of the result are not zero");

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_bitmap_slot_allocator_core.sv @@
// Self-checking testbench for bitmap_slot_allocator_core: directed and random
// allocate/free traffic with a scoreboard that tracks its own unit maps.
// Depends on bsa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_bitmap_slot_allocator_core;

  localparam int NumBlocks   = bsa_pkg::DefaultNumBlocks;
  localparam int SlotCount   = (NumBlocks < bsa_pkg::MaxSlots) ? NumBlocks : bsa_pkg::MaxSlots;
  localparam int RandomItems = 530;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 40;

  // One result as the block reports it.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] handle;
    logic       released;
  } reply_t;

  // A run that the stimulus believes is still allocated.
  typedef struct {
    logic [7:0]  handle;
    logic [15:0] mask;
  } run_t;

  // Keeps a private copy of every block's unit map, predicts the reply of
  // each accepted request and compares the replies in arrival order.
  class alloc_scoreboard;
    logic [15:0] slot_maps [SlotCount];
    reply_t      pending_replies [$];
    int          errors;
    int          reports;

    function new();
      foreach (slot_maps[i]) slot_maps[i] = '0;
      errors  = 0;
      reports = 0;
    endfunction

    // First fit over the live, not full blocks, else the first free slot.
    function reply_t place_run(logic [15:0] mask);
      reply_t      r;
      logic [31:0] shifted;
      r.status   = bsa_pkg::ST_OK;
      r.handle   = '0;
      r.released = 1'b0;
      if (mask != bsa_pkg::MapFull) begin
        for (int b = 0; b < SlotCount; b++) begin
          if (slot_maps[b] == '0 || slot_maps[b] == bsa_pkg::MapFull) continue;
          for (int off = 0; off < 16; off++) begin
            shifted = {16'h0000, mask} << off;
            if (shifted[31:16] != '0) break;
            if ((slot_maps[b] & shifted[15:0]) == '0) begin
              slot_maps[b] = slot_maps[b] | shifted[15:0];
              r.handle = 8'(b * 16 + off);
              return r;
            end
          end
        end
      end
      for (int b = 0; b < SlotCount; b++) begin
        if (slot_maps[b] == '0) begin
          slot_maps[b] = mask;
          r.handle = 8'(b * 16);
          return r;
        end
      end
      r.status = bsa_pkg::ST_NO_SPACE;
      return r;
    endfunction

    // Clears the shifted run; bits pushed past bit 15 are simply lost.
    function reply_t release_run(logic [15:0] mask, logic [7:0] hdl);
      reply_t      r;
      int          blk;
      logic [15:0] clear;
      blk        = hdl[7:4];
      r.status   = bsa_pkg::ST_OK;
      r.handle   = '0;
      r.released = 1'b0;
      if (blk >= SlotCount || slot_maps[blk] == '0) begin
        r.status = bsa_pkg::ST_NOT_LIVE;
        return r;
      end
      clear = mask << hdl[3:0];
      slot_maps[blk] = slot_maps[blk] & ~clear;
      r.released = (slot_maps[blk] == '0);
      return r;
    endfunction

    function reply_t note_request(logic cmd, logic [15:0] mask, logic [7:0] hdl);
      reply_t r;
      if (cmd == bsa_pkg::CMD_ALLOC) r = place_run(mask);
      else r = release_run(mask, hdl);
      pending_replies.push_back(r);
      return r;
    endfunction

    function void check_reply(logic [1:0] st, logic [7:0] hdl, logic rel);
      reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (reports < 10) begin
          reports++;
          $display("unexpected reply: status %0d handle %h released %b", st, hdl, rel);
        end
        return;
      end
      want = pending_replies.pop_front();
      if (st !== want.status || hdl !== want.handle || rel !== want.released) begin
        errors++;
        if (reports < 10) begin
          reports++;
          $display("reply mismatch: expected status %0d handle %h released %b, got %0d %h %b",
                   want.status, want.handle, want.released, st, hdl, rel);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  alloc_scoreboard sb = new();
  run_t            live_runs [$];
  int              burst_left = 0;
  int              rx_mode = 0;
  int              rx_left = 0;
  int              rx_phase = 0;
  int              idle_cycles = 0;

  bitmap_slot_allocator_core #(
    .NUM_BLOCKS(NumBlocks)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Presents one request and holds it until the block takes it. The sender
  // works in bursts; a burst may end by dropping tvalid for a random gap.
  task automatic push_request(input logic cmd, input logic [15:0] mask,
                              input logic [7:0] hdl, output reply_t r);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hdl, mask};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    r = sb.note_request(cmd, mask, hdl);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Mixes the mask shapes that matter for placement: full, empty, single
  // units, short runs at offset 0, shifted runs, full less one unit, noise.
  function automatic logic [15:0] pick_alloc_mask();
    int len;
    len = $urandom_range(1, 8);
    case ($urandom_range(0, 9))
      0: return bsa_pkg::MapFull;
      1: return 16'h0000;
      2: return 16'h0001 << $urandom_range(0, 15);
      3, 4, 5: return 16'((1 << len) - 1);
      6, 7: return 16'($urandom);
      8: return 16'(((1 << len) - 1) << $urandom_range(0, 15));
      default: return bsa_pkg::MapFull & ~(16'h0001 << $urandom_range(0, 15));
    endcase
  endfunction

  task automatic run_directed();
    reply_t r;
    // Zero mask with every slot free claims slot 0 and leaves it free.
    push_request(bsa_pkg::CMD_ALLOC, 16'h0000, 8'($urandom), r);
    push_request(bsa_pkg::CMD_ALLOC, 16'h0001, 8'($urandom), r);
    push_request(bsa_pkg::CMD_ALLOC, 16'h0003, 8'($urandom), r);
    // A full mask skips the scan and goes to a new block.
    push_request(bsa_pkg::CMD_ALLOC, bsa_pkg::MapFull, 8'($urandom), r);
    push_request(bsa_pkg::CMD_ALLOC, 16'h8000, 8'($urandom), r);
    // Zero mask with a live block fits at offset 0 of that block.
    push_request(bsa_pkg::CMD_ALLOC, 16'h0000, 8'($urandom), r);
    // Hits block 0 at offset 0 and overflows elsewhere, so takes a new block.
    push_request(bsa_pkg::CMD_ALLOC, 16'hFFFE, 8'($urandom), r);
    // Frees of blocks that are not live.
    push_request(bsa_pkg::CMD_FREE,  16'h0001, 8'h50, r);
    push_request(bsa_pkg::CMD_FREE,  16'h0004, 8'hF3, r);
    // A wide free at offset 15 keeps only its lowest bit.
    push_request(bsa_pkg::CMD_FREE,  bsa_pkg::MapFull, 8'h0F, r);
    push_request(bsa_pkg::CMD_FREE,  16'h0007, 8'h00, r);
    push_request(bsa_pkg::CMD_FREE,  16'h0001, 8'h00, r);
    push_request(bsa_pkg::CMD_FREE,  bsa_pkg::MapFull, 8'h10, r);
    // Freeing nothing, then freeing across the top edge of the map.
    push_request(bsa_pkg::CMD_FREE,  16'h0000, 8'h20, r);
    push_request(bsa_pkg::CMD_FREE,  16'h0003, 8'h2F, r);
    // Fill block 2 to the last unit, then spill into the free block 0.
    push_request(bsa_pkg::CMD_ALLOC, 16'h0001, 8'($urandom), r);
    push_request(bsa_pkg::CMD_ALLOC, 16'h0001, 8'($urandom), r);
    push_request(bsa_pkg::CMD_ALLOC, 16'h0001, 8'($urandom), r);
    push_request(bsa_pkg::CMD_FREE,  16'h0001, 8'h00, r);
    push_request(bsa_pkg::CMD_FREE,  bsa_pkg::MapFull, 8'h20, r);
  endtask

  // Alternates allocate-heavy stretches, which run the slots out of space,
  // with free-heavy stretches that release them again. Most frees return a
  // run that was handed out; the rest are random handles and masks.
  task automatic run_random();
    reply_t      r;
    run_t        run;
    int          idx;
    int          alloc_pct;
    logic [15:0] mask;
    for (int n = 0; n < RandomItems; n++) begin
      alloc_pct = ((n / 60) % 2 == 0) ? 80 : 35;
      if (live_runs.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
        mask = pick_alloc_mask();
        push_request(bsa_pkg::CMD_ALLOC, mask, 8'($urandom), r);
        if (r.status == bsa_pkg::ST_OK && mask != '0) begin
          run.handle = r.handle;
          run.mask   = mask;
          live_runs.push_back(run);
        end
      end else if ($urandom_range(0, 4) != 0) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        run = live_runs[idx];
        live_runs.delete(idx);
        // Now and then only part of the run is returned.
        if ($urandom_range(0, 5) == 0) run.mask = run.mask & 16'($urandom);
        push_request(bsa_pkg::CMD_FREE, run.mask, run.handle, r);
      end else begin
        push_request(bsa_pkg::CMD_FREE, 16'($urandom), 8'($urandom), r);
      end
    end
  endtask

  // The receiver picks a stall pattern, keeps it for a while, then moves on.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = (rx_mode == 2) ? $urandom_range(1, 40) : $urandom_range(10, 200);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= 1'b0;
      default: m_axis_tready <= (rx_phase % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_reply(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8]);
    end
  end

  // Ends a hung run: too many cycles in a row with no transaction on
  // either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/bsa_pkg.sv
design/bsa_cell.sv
design/bitmap_slot_allocator_core.sv
design/bsa_checker.sv
tb/tb_bitmap_slot_allocator_core.sv
